@@ hdl/smd_pkg.sv @@
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants of the side marker detector
// Register indexes, reset values, counter widths and the structs passed
// between the configuration block, the side detectors and the top level.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int unsigned WinW    = 12;
  localparam int unsigned BoostW  = 8;
  localparam int unsigned ArmW    = 16;
  localparam int unsigned DelayW  = 12;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned SideElW = 16;
  localparam int unsigned RunElW  = 17;
  localparam int unsigned StopElW = 13;
  localparam int unsigned LedElW  = 13;
  localparam int unsigned CountW  = 8;

  localparam logic [WinW-1:0]   WindowRst = WinW'(100);
  localparam logic [BoostW-1:0] BoostRst  = BoostW'(255);
  localparam logic [ArmW-1:0]   ArmRst    = ArmW'(35000);
  localparam logic [DelayW-1:0] DelayRst  = DelayW'(300);

  // LED bit positions in the LED state
  localparam int unsigned LedLeft  = 0;
  localparam int unsigned LedRight = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_BOOST  = 2'd1,
    CFG_ARM    = 2'd2,
    CFG_DELAY  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WinW-1:0]   window;
    logic [BoostW-1:0] boost;
    logic [ArmW-1:0]   arm;
    logic [DelayW-1:0] delay;
  } cfg_t;

  typedef struct packed {
    logic               gate;
    logic               checking;
    logic [SideElW-1:0] elapsed;
  } side_st_t;

  typedef struct packed {
    side_st_t   st;
    logic       mark;
    logic       crossed;
    logic [1:0] light;
  } side_res_t;

endpackage

@@ hdl/side_marker_detector_unit.sv @@
// ----------------------------------------------------------------------------
// side_marker_detector_unit: side marker qualification and run control
// Qualifies left and right side marker readings on millisecond ticks, counts
// left marks, selects boost, detects the end mark and requests the stop.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake               | Word
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o | action, left_side, right_side
//  out      | out_valid_o/out_stall_i | marks, crossing, count, flags, LEDs
//  cfg      | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
//  One word is taken per cycle while in_stall_o is low. A word waits in the
//  input register; the detector state updates as it moves into the output
//  register, where its result is valid and leaves once out_stall_i is low.
//  Reset clears all control state; configuration returns to its defaults.
//  A stalled output word holds the input register; a third word stalls in.
//
module side_marker_detector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic                        left_side_i,
  input  logic                        right_side_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        left_mark_o,
  output logic                        right_mark_o,
  output logic                        crossing_o,
  output logic [smd_pkg::CountW-1:0]  mark_count_o,
  output logic                        boost_active_o,
  output logic                        end_seen_o,
  output logic                        stop_request_o,
  output logic                        led_left_o,
  output logic                        led_right_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [smd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [smd_pkg::CfgW-1:0]    cfg_wdata_i
);

  smd_pkg::cfg_t cfg;

  smd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // ---------------- input register ----------------
  logic in_vld_q;
  logic act_q, lft_q, rgt_q;
  logic advance;

  // move the held word into the output stage when that stage is free
  assign advance    = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q <= action_i;
      lft_q <= left_side_i;
      rgt_q <= right_side_i;
    end
  end

  // ---------------- detector and run state ----------------
  smd_pkg::side_st_t           lst_q, rst_q;
  logic [smd_pkg::CountW-1:0]  marks_q, marks_d;
  logic                        boost_q, boost_d;
  logic [smd_pkg::RunElW-1:0]  run_el_q, run_el_d;
  logic                        running_q, running_d;
  logic                        end_q, end_d;
  logic [smd_pkg::StopElW-1:0] stop_el_q, stop_el_d;
  logic [1:0]                  led_q, led_d;
  logic [smd_pkg::LedElW-1:0]  led_el_q, led_el_d;
  smd_pkg::side_st_t           lst_d, rst_d;

  smd_pkg::side_res_t lres, rres;
  logic lm, rm, cross_hit;

  smd_side u_left (
    .st_i      (lst_q),
    .own_i     (lft_q),
    .other_i   (rgt_q),
    .own_led_i (2'b01),
    .window_i  (cfg.window),
    .res_o     (lres)
  );

  smd_side u_right (
    .st_i      (rst_q),
    .own_i     (rgt_q),
    .other_i   (lft_q),
    .own_led_i (2'b10),
    .window_i  (cfg.window),
    .res_o     (rres)
  );

  always_comb begin
    lst_d     = lst_q;
    rst_d     = rst_q;
    marks_d   = marks_q;
    boost_d   = boost_q;
    run_el_d  = run_el_q;
    running_d = running_q;
    end_d     = end_q;
    stop_el_d = stop_el_q;
    led_d     = led_q;
    led_el_d  = led_el_q;
    lm        = 1'b0;
    rm        = 1'b0;
    cross_hit = 1'b0;

    if (act_q) begin
      // start of a run: no timer advances, no samples taken
      running_d = 1'b1;
      end_d     = 1'b0;
      marks_d   = '0;
      boost_d   = 1'b0;
      run_el_d  = '0;
    end else begin
      lst_d     = lres.st;
      rst_d     = rres.st;
      lm        = lres.mark;
      rm        = rres.mark;
      cross_hit = lres.crossed | rres.crossed;
      run_el_d  = (&run_el_q)  ? run_el_q  : run_el_q + 1'b1;
      stop_el_d = (&stop_el_q) ? stop_el_q : stop_el_q + 1'b1;
      led_el_d  = (&led_el_q)  ? led_el_q  : led_el_q + 1'b1;

      // any lighting restarts the LED hold time
      if (|(lres.light | rres.light)) begin
        led_d    = led_q | lres.light | rres.light;
        led_el_d = '0;
      end

      if (running_q && lm) begin
        marks_d = (&marks_q) ? marks_q : marks_q + 1'b1;
        if (marks_d >= cfg.boost) begin
          boost_d = 1'b1;
        end
      end

      // end mark arms after the arm time; stop follows the delay after end
      if (running_q && (run_el_d > smd_pkg::RunElW'(cfg.arm))) begin
        if (rm && !end_q) begin
          end_d     = 1'b1;
          stop_el_d = '0;
        end else if (end_q && (stop_el_d > smd_pkg::StopElW'(cfg.delay))) begin
          running_d = 1'b0;
        end
      end

      if ((|led_d) && (led_el_d > smd_pkg::LedElW'(cfg.window))) begin
        led_d = 2'b00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lst_q     <= '{gate: 1'b0, checking: 1'b0, elapsed: '1};
      rst_q     <= '{gate: 1'b0, checking: 1'b0, elapsed: '1};
      marks_q   <= '0;
      boost_q   <= 1'b0;
      run_el_q  <= '0;
      running_q <= 1'b0;
      end_q     <= 1'b0;
      stop_el_q <= '0;
      led_q     <= 2'b00;
      led_el_q  <= '0;
    end else if (advance) begin
      lst_q     <= lst_d;
      rst_q     <= rst_d;
      marks_q   <= marks_d;
      boost_q   <= boost_d;
      run_el_q  <= run_el_d;
      running_q <= running_d;
      end_q     <= end_d;
      stop_el_q <= stop_el_d;
      led_q     <= led_d;
      led_el_q  <= led_el_d;
    end
  end

  // ---------------- output register ----------------
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      left_mark_o    <= lm;
      right_mark_o   <= rm;
      crossing_o     <= cross_hit;
      mark_count_o   <= marks_d;
      boost_active_o <= boost_d;
      end_seen_o     <= end_d;
      stop_request_o <= end_d && !running_d;
      led_left_o     <= led_d[smd_pkg::LedLeft];
      led_right_o    <= led_d[smd_pkg::LedRight];
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ hdl/smd_cfg.sv @@
// ----------------------------------------------------------------------------
// smd_cfg: configuration registers
// Four write-only registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module smd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [smd_pkg::CfgW-1:0]    cfg_wdata_i,
  output smd_pkg::cfg_t               cfg_o
);

  smd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= smd_pkg::WindowRst;
      cfg_q.boost  <= smd_pkg::BoostRst;
      cfg_q.arm    <= smd_pkg::ArmRst;
      cfg_q.delay  <= smd_pkg::DelayRst;
    end else if (cfg_we_i) begin
      case (smd_pkg::cfg_idx_e'(cfg_index_i))
        smd_pkg::CFG_WINDOW: cfg_q.window <= cfg_wdata_i[smd_pkg::WinW-1:0];
        smd_pkg::CFG_BOOST:  cfg_q.boost  <= cfg_wdata_i[smd_pkg::BoostW-1:0];
        smd_pkg::CFG_ARM:    cfg_q.arm    <= cfg_wdata_i[smd_pkg::ArmW-1:0];
        smd_pkg::CFG_DELAY:  cfg_q.delay  <= cfg_wdata_i[smd_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/smd_side.sv @@
// ----------------------------------------------------------------------------
// smd_side: one side marker detector
// Next state of one side for a tick: open window, crossing, confirmed mark, gate release.
// ----------------------------------------------------------------------------
module smd_side (
  input  smd_pkg::side_st_t          st_i,
  input  logic                       own_i,
  input  logic                       other_i,
  input  logic [1:0]                 own_led_i,
  input  logic [smd_pkg::WinW-1:0]   window_i,
  output smd_pkg::side_res_t         res_o
);

  logic [smd_pkg::SideElW-1:0] el;
  logic [smd_pkg::SideElW-1:0] win_ext;
  logic                        in_win;

  always_comb begin
    // advance elapsed, saturating
    el      = (&st_i.elapsed) ? st_i.elapsed : st_i.elapsed + 1'b1;
    win_ext = smd_pkg::SideElW'(window_i);
    in_win  = (el < win_ext);

    res_o.st       = st_i;
    res_o.st.elapsed = el;
    res_o.mark     = 1'b0;
    res_o.crossed  = 1'b0;
    res_o.light    = 2'b00;

    if (own_i && !st_i.gate) begin
      res_o.st.gate     = 1'b1;
      res_o.st.checking = 1'b1;
      res_o.st.elapsed  = '0;
    end else if (in_win && other_i) begin
      res_o.st.checking = 1'b0;
      res_o.crossed     = 1'b1;
      res_o.light       = 2'b11;
    end else if (!in_win && st_i.checking) begin
      res_o.st.checking = 1'b0;
      res_o.mark        = 1'b1;
      res_o.light       = own_led_i;
    end else if (el > win_ext) begin
      res_o.st.gate = 1'b0;
    end
  end

endmodule

@@ hdl/smd_checker.sv @@
// ----------------------------------------------------------------------------
// smd_checker: port-level checks of the side marker detector
// Watches the top level's ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module smd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       left_mark_o,
  input logic                       crossing_o,
  input logic [smd_pkg::CountW-1:0] mark_count_o,
  input logic                       boost_active_o,
  input logic                       end_seen_o,
  input logic                       stop_request_o,
  input logic                       led_left_o,
  input logic                       led_right_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mark_count_o)
      && $stable(end_seen_o) && $stable(led_left_o))
    else $error("stalled result word changed");

  a_stop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_request_o |-> end_seen_o)
    else $error("stop request without end mark");

  a_cross_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crossing_o |-> led_left_o && led_right_o)
    else $error("crossing without both LEDs lit");

  a_mark_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && left_mark_o |-> led_left_o)
    else $error("left mark without left LED");

  a_boost_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mark_count_o == '0) |-> !boost_active_o)
    else $error("boost active with no marks counted");

endmodule

bind side_marker_detector_unit smd_checker u_smd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .left_mark_o    (left_mark_o),
  .crossing_o     (crossing_o),
  .mark_count_o   (mark_count_o),
  .boost_active_o (boost_active_o),
  .end_seen_o     (end_seen_o),
  .stop_request_o (stop_request_o),
  .led_left_o     (led_left_o),
  .led_right_o    (led_right_o)
);

@@ sim/side_marker_detector_unit_test.sv @@
// ----------------------------------------------------------------------------
// side_marker_detector_unit_test: self-checking bench for the side marker unit
// Walks a short directed plan, then randomized phases of marker pulses,
// crossings, restarts and sensor noise under several register settings and
// idle patterns. Every result word is matched field by field against a
// cycle-free detector model kept in the bench, or against a typed plan result.
// ----------------------------------------------------------------------------
module side_marker_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_e;

  typedef enum logic {
    STEP_WORD = 1'b0,
    STEP_CFG  = 1'b1
  } step_e;

  typedef struct packed {
    logic                       left_mark;
    logic                       right_mark;
    logic                       crossing;
    logic [smd_pkg::CountW-1:0] count;
    logic                       boost;
    logic                       end_seen;
    logic                       stop;
    logic                       led_left;
    logic                       led_right;
  } marker_report_t;

  typedef struct packed {
    step_e                    kind;
    action_e                  act;
    logic                     side_l;
    logic                     side_r;
    smd_pkg::cfg_idx_e        idx;
    logic [smd_pkg::CfgW-1:0] data;
    logic                     typed;
    marker_report_t           want;
  } plan_row_t;

  // one randomized phase: register values, traffic mix and idle pattern
  typedef struct packed {
    logic [smd_pkg::CfgW-1:0] window;
    logic [smd_pkg::CfgW-1:0] boost;
    logic [smd_pkg::CfgW-1:0] arm;
    logic [smd_pkg::CfgW-1:0] delay;
    int              items;
    int              start_pct;
    int              noise_pct;
    int              left_pct;
    int              cross_pct;
    int              max_high;
    int              min_low;
    int              max_low;
    int              idle_pct;
    int              stall_pct;
    bit              pause_mid;
  } phase_t;

  localparam marker_report_t Quiet = '0;
  localparam logic [1:0] LeftLit  = 2'(1) << smd_pkg::LedLeft;
  localparam logic [1:0] RightLit = 2'(1) << smd_pkg::LedRight;

  // Directed plan. Only the two words right after reset carry a typed result:
  // nothing is running, no window is open and both LEDs are dark.
  localparam plan_row_t Plan [26] = '{
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b1, Quiet},
    '{STEP_WORD, ACT_START, 1'b1, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b1, Quiet},
    '{STEP_CFG,  ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd2, 1'b0, Quiet},
    '{STEP_CFG,  ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_BOOST,  16'd1, 1'b0, Quiet},
    '{STEP_CFG,  ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_ARM,    16'd3, 1'b0, Quiet},
    '{STEP_CFG,  ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_DELAY,  16'd1, 1'b0, Quiet},
    // left pulse confirmed at the end of its window, boost at threshold one
    '{STEP_WORD, ACT_TICK,  1'b1, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    // right mark after the arm time: end, then stop one delay later
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    // restart clears end and stop; then a crossing inside the window
    '{STEP_WORD, ACT_START, 1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b1, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b1, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    // zero window: no crossing is possible, LEDs drop one tick after lighting
    '{STEP_CFG,  ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b1, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b1, 1'b1, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet},
    '{STEP_WORD, ACT_TICK,  1'b0, 1'b0, smd_pkg::CFG_WINDOW, 16'd0, 1'b0, Quiet}
  };

  // Random phases. The long one keeps a single run alive with dense left
  // pulses so the mark count reaches and holds saturation.
  localparam phase_t Phases [4] = '{
    '{16'h0003, 16'h0000, 16'h0000, 16'h0000,
      150, 4, 15, 50, 25, 2, 0, 5, 56, 0, 1'b0},
    '{16'h0000, 16'h00FF, 16'hFFFF, 16'h0FFF,
      1000, 0, 5, 95, 0, 1, 2, 2, 0, 56, 1'b0},
    '{16'hFFFF, 16'h0003, 16'h000A, 16'h0014,
      60, 5, 20, 50, 40, 3, 0, 8, 12, 12, 1'b0},
    '{16'hF006, 16'hAB02, 16'h001E, 16'h5008,
      120, 3, 15, 50, 20, 2, 0, 9, 0, 0, 1'b1}
  };

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic                          action_i     = 1'b0;
  logic                          left_side_i  = 1'b0;
  logic                          right_side_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic                          left_mark_o;
  logic                          right_mark_o;
  logic                          crossing_o;
  logic [smd_pkg::CountW-1:0]    mark_count_o;
  logic                          boost_active_o;
  logic                          end_seen_o;
  logic                          stop_request_o;
  logic                          led_left_o;
  logic                          led_right_o;
  logic                          cfg_we_i     = 1'b0;
  logic [smd_pkg::CfgIdxW-1:0]   cfg_index_i  = '0;
  logic [smd_pkg::CfgW-1:0]      cfg_wdata_i  = '0;

  side_marker_detector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .left_side_i    (left_side_i),
    .right_side_i   (right_side_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_mark_o    (left_mark_o),
    .right_mark_o   (right_mark_o),
    .crossing_o     (crossing_o),
    .mark_count_o   (mark_count_o),
    .boost_active_o (boost_active_o),
    .end_seen_o     (end_seen_o),
    .stop_request_o (stop_request_o),
    .led_left_o     (led_left_o),
    .led_right_o    (led_right_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Detector model: its own copy of the registers and the run state
  // --------------------------------------------------------------------------
  smd_pkg::cfg_t                 cfg_model;
  smd_pkg::side_st_t             left_st, right_st;
  logic [smd_pkg::CountW-1:0]    marks;
  logic                          boost_on;
  logic [smd_pkg::RunElW-1:0]    run_el;
  logic                          running;
  logic                          end_on;
  logic [smd_pkg::StopElW-1:0]   stop_el;
  logic [1:0]                    leds;
  logic [smd_pkg::LedElW-1:0]    led_el;

  marker_report_t due_reports [$];
  int idle_pct    = 0;
  int stall_pct   = 0;
  int mismatches  = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int left_seen   = 0;
  int right_seen  = 0;
  int cross_seen  = 0;
  int stops_seen  = 0;
  int peak_count  = 0;

  // One side's detector for one tick: open, cross, confirm, or age out.
  function automatic void side_step(inout smd_pkg::side_st_t st, input logic own,
                                    input logic other, input logic [1:0] own_led,
                                    inout logic crossed, output logic mark);
    mark = 1'b0;
    if (own && !st.gate) begin
      st.gate     = 1'b1;
      st.checking = 1'b1;
      st.elapsed  = '0;
    end else if (st.elapsed < cfg_model.window) begin
      if (other) begin
        leds        = 2'b11;
        led_el      = '0;
        st.checking = 1'b0;
        crossed     = 1'b1;
        return;
      end
    end else if (st.checking) begin
      st.checking = 1'b0;
      leds        = leds | own_led;
      led_el      = '0;
      mark        = 1'b1;
      return;
    end
    if (st.elapsed > cfg_model.window) st.gate = 1'b0;
  endfunction

  // Advance the model by one accepted word and return the report it causes.
  function automatic marker_report_t advance_markers(action_e act, logic l, logic r);
    marker_report_t rep;
    logic lm, rm, crossed;
    lm      = 1'b0;
    rm      = 1'b0;
    crossed = 1'b0;
    if (act == ACT_START) begin
      running  = 1'b1;
      end_on   = 1'b0;
      marks    = '0;
      boost_on = 1'b0;
      run_el   = '0;
    end else begin
      if (!(&left_st.elapsed))  left_st.elapsed++;
      if (!(&right_st.elapsed)) right_st.elapsed++;
      if (!(&run_el))  run_el++;
      if (!(&stop_el)) stop_el++;
      if (!(&led_el))  led_el++;
      side_step(left_st, l, r, LeftLit, crossed, lm);
      side_step(right_st, r, l, RightLit, crossed, rm);
      if (running && lm) begin
        if (!(&marks)) marks++;
        if (marks >= cfg_model.boost) boost_on = 1'b1;
      end
      if (running && run_el > cfg_model.arm) begin
        if (rm && !end_on) begin
          end_on  = 1'b1;
          stop_el = '0;
        end else if (end_on && stop_el > cfg_model.delay) begin
          running = 1'b0;
        end
      end
      if (leds != 2'b00 && led_el > cfg_model.window) leds = 2'b00;
    end
    rep = '{lm, rm, crossed, marks, boost_on, end_on, end_on && !running,
            leds[smd_pkg::LedLeft], leds[smd_pkg::LedRight]};
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: all inputs change on the falling edge
  // --------------------------------------------------------------------------

  // Offer one word, idling first at random; queue its report, hold until taken.
  task automatic send_word(input action_e act, input logic l, input logic r,
                           input logic typed = 1'b0, input marker_report_t want = '0);
    marker_report_t rep;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i   = 1'b0;
      action_i     = 1'($urandom_range(0, 1));
      left_side_i  = 1'($urandom_range(0, 1));
      right_side_i = 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    left_side_i  = l;
    right_side_i = r;
    rep = advance_markers(act, l, r);
    due_reports.push_back(typed ? want : rep);
    words_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every queued report has come back.
  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input smd_pkg::cfg_idx_e idx,
                           input logic [smd_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      smd_pkg::CFG_WINDOW: cfg_model.window = data[smd_pkg::WinW-1:0];
      smd_pkg::CFG_BOOST:  cfg_model.boost  = data[smd_pkg::BoostW-1:0];
      smd_pkg::CFG_ARM:    cfg_model.arm    = data[smd_pkg::ArmW-1:0];
      smd_pkg::CFG_DELAY:  cfg_model.delay  = data[smd_pkg::DelayW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed marker pulses (own side high, then low through the
  // window, sometimes the other side high inside it), plus restarts and noise.
  task automatic run_mix(input phase_t ph);
    int   sent, pick, high_n, low_n, cross_at, n;
    logic on_left, own, other;
    bit   paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < ph.items) begin
      if (ph.pause_mid && !paused && sent >= ph.items / 2) begin
        drain_words();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < ph.start_pct) begin
        send_word(ACT_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < ph.start_pct + ph.noise_pct) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_word(ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        on_left  = ($urandom_range(0, 99) < ph.left_pct);
        high_n   = $urandom_range(1, ph.max_high);
        low_n    = $urandom_range(ph.min_low, ph.max_low);
        cross_at = ($urandom_range(0, 99) < ph.cross_pct) ?
                   $urandom_range(0, high_n + low_n - 1) : -1;
        for (int k = 0; k < high_n + low_n; k++) begin
          own   = (k < high_n);
          other = (k == cross_at);
          send_word(ACT_TICK, on_left ? own : other, on_left ? other : own);
          sent++;
        end
      end
    end
  endtask

  // receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result check on the rising edge
  // --------------------------------------------------------------------------
  marker_report_t seen_rep, due_rep;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_rep = '{left_mark_o, right_mark_o, crossing_o, mark_count_o, boost_active_o,
                   end_seen_o, stop_request_o, led_left_o, led_right_o};
      words_seen++;
      if (due_reports.size() == 0) begin
        $error("result word arrived with no word outstanding");
        mismatches++;
      end else begin
        due_rep = due_reports.pop_front();
        check_field("left_mark",    due_rep.left_mark,  seen_rep.left_mark);
        check_field("right_mark",   due_rep.right_mark, seen_rep.right_mark);
        check_field("crossing",     due_rep.crossing,   seen_rep.crossing);
        check_field("mark_count",   due_rep.count,      seen_rep.count);
        check_field("boost_active", due_rep.boost,      seen_rep.boost);
        check_field("end_seen",     due_rep.end_seen,   seen_rep.end_seen);
        check_field("stop_request", due_rep.stop,       seen_rep.stop);
        check_field("led_left",     due_rep.led_left,   seen_rep.led_left);
        check_field("led_right",    due_rep.led_right,  seen_rep.led_right);
      end
      left_seen  += seen_rep.left_mark;
      right_seen += seen_rep.right_mark;
      cross_seen += seen_rep.crossing;
      stops_seen += seen_rep.stop;
      if (seen_rep.count > peak_count) peak_count = seen_rep.count;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_model = '{smd_pkg::WindowRst, smd_pkg::BoostRst, smd_pkg::ArmRst,
                  smd_pkg::DelayRst};
    left_st   = '{1'b0, 1'b0, '1};
    right_st  = '{1'b0, 1'b0, '1};
    marks     = '0;
    boost_on  = 1'b0;
    run_el    = '0;
    running   = 1'b0;
    end_on    = 1'b0;
    stop_el   = '0;
    leds      = 2'b00;
    led_el    = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed plan, no idling on either side
    foreach (Plan[i]) begin
      if (Plan[i].kind == STEP_CFG) begin
        drain_words();
        write_reg(Plan[i].idx, Plan[i].data);
      end else begin
        send_word(Plan[i].act, Plan[i].side_l, Plan[i].side_r, Plan[i].typed, Plan[i].want);
      end
    end

    // random phases: quiesce, reprogram every register, restart the run
    foreach (Phases[p]) begin
      drain_words();
      idle_pct  = Phases[p].idle_pct;
      stall_pct = Phases[p].stall_pct;
      write_reg(smd_pkg::CFG_WINDOW, Phases[p].window);
      write_reg(smd_pkg::CFG_BOOST,  Phases[p].boost);
      write_reg(smd_pkg::CFG_ARM,    Phases[p].arm);
      write_reg(smd_pkg::CFG_DELAY,  Phases[p].delay);
      send_word(ACT_START, 1'b0, 1'b0);
      run_mix(Phases[p]);
    end

    drain_words();
    repeat (4) @(posedge clk_i);

    $display("Checked %0d of %0d words across %0d register settings.",
             words_seen, words_sent, $size(Phases) + 3);
    $display("Seen: %0d left marks, %0d right marks, %0d crossings,",
             left_seen, right_seen, cross_seen);
    $display("      %0d stopped words, peak count %0d.", stops_seen, peak_count);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #400_000;
    $display("timeout with %0d result words still outstanding", due_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/smd_pkg.sv
hdl/smd_cfg.sv
hdl/smd_side.sv
hdl/side_marker_detector_unit.sv
hdl/smd_checker.sv
sim/side_marker_detector_unit_test.sv
